FILE: sv/acpu_pkg.sv
// Package with the payload types, opcodes and control types of the accumulator CPU.
package acpu_pkg;

   typedef struct packed {
      logic        opcode;
      logic [10:0] load_address;
      logic [31:0] load_value;
      logic [6:0]  random_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  port_kind;
      logic [31:0] port_value;
      logic [2:0]  run_status;
      logic [31:0] program_counter_out;
   } rsp_type;

   // Item kinds.
   localparam logic ITEM_LOAD = 1'b0;

   // Instruction codes.
   localparam logic [31:0] OP_EMPTY = 32'd0;
   localparam logic [31:0] OP_LDI   = 32'd1;
   localparam logic [31:0] OP_LDD   = 32'd2;
   localparam logic [31:0] OP_LDN   = 32'd3;
   localparam logic [31:0] OP_LDX   = 32'd4;
   localparam logic [31:0] OP_LDY   = 32'd5;
   localparam logic [31:0] OP_LDS   = 32'd6;
   localparam logic [31:0] OP_STO   = 32'd7;
   localparam logic [31:0] OP_GET   = 32'd8;
   localparam logic [31:0] OP_PUT   = 32'd9;
   localparam logic [31:0] OP_ADDX  = 32'd10;
   localparam logic [31:0] OP_ADDY  = 32'd11;
   localparam logic [31:0] OP_SUBX  = 32'd12;
   localparam logic [31:0] OP_SUBY  = 32'd13;
   localparam logic [31:0] OP_CPAX  = 32'd14;
   localparam logic [31:0] OP_CPXA  = 32'd15;
   localparam logic [31:0] OP_CPAY  = 32'd16;
   localparam logic [31:0] OP_CPYA  = 32'd17;
   localparam logic [31:0] OP_CPAS  = 32'd18;
   localparam logic [31:0] OP_CPSA  = 32'd19;
   localparam logic [31:0] OP_JMP   = 32'd20;
   localparam logic [31:0] OP_JZ    = 32'd21;
   localparam logic [31:0] OP_JNZ   = 32'd22;
   localparam logic [31:0] OP_CALL  = 32'd23;
   localparam logic [31:0] OP_RET   = 32'd24;
   localparam logic [31:0] OP_INCX  = 32'd25;
   localparam logic [31:0] OP_DECX  = 32'd26;
   localparam logic [31:0] OP_PUSH  = 32'd27;
   localparam logic [31:0] OP_POP   = 32'd28;
   localparam logic [31:0] OP_SYS   = 32'd29;
   localparam logic [31:0] OP_IRET  = 32'd30;
   localparam logic [31:0] OP_EXIT  = 32'd50;

   // Port numbers of the output instruction.
   localparam logic [31:0] PORT_INT  = 32'd1;
   localparam logic [31:0] PORT_CHAR = 32'd2;
   localparam logic [1:0]  PK_NONE   = 2'd0;
   localparam logic [1:0]  PK_INT    = 2'd1;
   localparam logic [1:0]  PK_CHAR   = 2'd2;

   // Interrupt kinds.
   localparam logic [1:0] INT_NONE    = 2'd0;
   localparam logic [1:0] INT_SYSCALL = 2'd1;
   localparam logic [1:0] INT_TIMER   = 2'd2;

   // Run status codes.
   localparam logic [2:0] ST_RUN     = 3'd0;
   localparam logic [2:0] ST_EXIT    = 3'd1;
   localparam logic [2:0] ST_MEMV    = 3'd2;
   localparam logic [2:0] ST_EMPTY   = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;
   localparam logic [2:0] ST_PORT    = 3'd5;
   localparam logic [2:0] ST_NESTED  = 3'd6;
   localparam logic [2:0] ST_OVERRUN = 3'd7;

   localparam logic [31:0] ADDR_TIMER_HANDLER   = 32'd1000;
   localparam logic [31:0] ADDR_SYSCALL_HANDLER = 32'd1500;
   localparam logic [15:0] TIMER_PERIOD_RESET   = 16'd100;

   typedef enum logic [3:0] {
      PH_CLEAR,
      PH_IDLE,
      PH_FETCH,
      PH_DECODE,
      PH_OPND,
      PH_DATA,
      PH_DATA2,
      PH_IRET1,
      PH_IRET2,
      PH_TIMER,
      PH_PUSH2,
      PH_DONE
   } phase_type;

   typedef struct packed {
      phase_type phase;
      logic      accept;
      logic      load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [31:0] ir;
      logic        halt;
      logic [1:0]  intk;
      logic        timer_due;
      logic        stopped;
      logic        rsp_free;
      logic        clear_last;
   } status_type;

endpackage

FILE: sv/accumulator_cpu_with_interrupts_core.sv
// Accumulator CPU with timer and system-call interrupts: top level.
// Results: a load item, or an execute item once the CPU has stopped, goes straight to
// its result beat; other execute items first run a chain of single-port memory accesses.
// Throughput: one item at a time; the next one is accepted in the same cycle as its
// result is offered, and a result waits while an earlier result beat is not yet taken.
// Reset: synchronous; a clearing pass then zeroes every memory word and no item is
// accepted until it ends (period register writes are taken).
module accumulator_cpu_with_interrupts_core import acpu_pkg::*; #(
   parameter int MEM_WORDS = 2000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   cmd_type    cmd;
   status_type st;

   // Sequencer.
   acpu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_payload.opcode),
      .req_ready  (req_ready),
      .st         (st),
      .cmd        (cmd)
   );

   // Registers and memory.
   acpu_datapath #(.MEM_WORDS(MEM_WORDS)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload)
   );

endmodule

FILE: sv/acpu_ctrl.sv
// Controller state machine that sequences the phases of one instruction.
module acpu_ctrl import acpu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_opcode,
   output logic       req_ready,
   input  status_type st,
   output cmd_type    cmd
);

   phase_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PH_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd.phase    = state_ff;
      cmd.accept   = 1'b0;
      cmd.load_rsp = 1'b0;
      req_ready    = (state_ff == PH_IDLE);
      case (state_ff)
         PH_CLEAR: begin
            if (st.clear_last) state_in = PH_IDLE;
         end
         PH_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_opcode == ITEM_LOAD || st.stopped) state_in = PH_DONE;
               else state_in = PH_FETCH;
            end
         end
         PH_FETCH: begin
            state_in = st.halt ? PH_DONE : PH_DECODE;
         end
         PH_DECODE: begin
            if (st.halt) begin
               state_in = PH_DONE;
            end else if (st.ir inside {OP_LDI, OP_LDD, OP_LDN, OP_LDX, OP_LDY, OP_STO,
                                       OP_PUT, OP_JMP, OP_JZ, OP_JNZ, OP_CALL}) begin
               state_in = PH_OPND;
            end else if (st.ir inside {OP_LDS, OP_RET, OP_POP}) begin
               state_in = PH_DATA2;
            end else if (st.ir == OP_IRET) begin
               state_in = PH_IRET1;
            end else if (st.ir == OP_SYS) begin
               state_in = PH_PUSH2;
            end else begin
               state_in = PH_TIMER;
            end
         end
         PH_OPND: begin
            if (st.halt) state_in = PH_DONE;
            else if (st.ir inside {OP_LDD, OP_LDN}) state_in = PH_DATA;
            else if (st.ir inside {OP_LDX, OP_LDY}) state_in = PH_DATA2;
            else state_in = PH_TIMER;
         end
         PH_DATA: begin
            if (st.halt) state_in = PH_DONE;
            else if (st.ir == OP_LDN) state_in = PH_DATA2;
            else state_in = PH_TIMER;
         end
         PH_DATA2: begin
            state_in = st.halt ? PH_DONE : PH_TIMER;
         end
         PH_IRET1: begin
            state_in = st.halt ? PH_DONE : PH_IRET2;
         end
         PH_IRET2: begin
            state_in = st.halt ? PH_DONE : PH_TIMER;
         end
         PH_PUSH2: begin
            state_in = (st.intk == INT_SYSCALL) ? PH_TIMER : PH_DONE;
         end
         PH_TIMER: begin
            state_in = st.timer_due ? PH_PUSH2 : PH_DONE;
         end
         PH_DONE: begin
            if (st.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = PH_IDLE;
            end
         end
         default: begin
            state_in = PH_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/acpu_datapath.sv
// Datapath with the word memory, the CPU registers and the result register.
module acpu_datapath import acpu_pkg::*; #(
   parameter int MEM_WORDS = 2000
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  st,
   input  req_type     req_payload,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam logic [31:0] MEM_W    = 32'(MEM_WORDS);
   localparam logic [31:0] MEM_H    = 32'(MEM_WORDS / 2);
   localparam logic [31:0] MEM_TOP1 = 32'(MEM_WORDS - 1);
   localparam logic [31:0] MEM_TOP2 = 32'(MEM_WORDS - 2);
   localparam logic [AW-1:0] CLR_LAST = AW'(MEM_WORDS - 1);

   logic [31:0] mem [MEM_WORDS];
   logic [31:0] rdata_ff;

   logic [31:0] pc_ff, pc_in, sp_ff, sp_in, acc_ff, acc_in;
   logic [31:0] x_ff, x_in, y_ff, y_in, tick_ff, tick_in;
   logic        km_ff, km_in;
   logic [1:0]  intk_ff, intk_in;
   logic [2:0]  stop_ff, stop_in;
   logic [15:0] period_ff;
   logic [AW-1:0] clr_ff, clr_in;
   logic [31:0] ir_ff, ir_in, ssp_ff, ssp_in;
   logic [1:0]  pk_ff, pk_in;
   logic [31:0] pv_ff, pv_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [31:0] a, wdata;
   logic        chk, wr_req, bad, we, halt;
   logic [31:0] tick_inc;
   logic        timer_due;

   function automatic logic addr_bad(input logic [31:0] ad, input logic k);
      return (ad >= MEM_W) || (!k && ad >= MEM_H);
   endfunction

   assign tick_inc  = tick_ff + 32'd1;
   assign timer_due = (intk_ff == INT_NONE) && (tick_ff >= {16'd0, period_ff});

   // Phase actions: memory access, register updates and error detection.
   always_comb begin
      pc_in   = pc_ff;   sp_in  = sp_ff;  acc_in = acc_ff;
      x_in    = x_ff;    y_in   = y_ff;   tick_in = tick_ff;
      km_in   = km_ff;   intk_in = intk_ff; stop_in = stop_ff;
      clr_in  = clr_ff;  ir_in  = ir_ff;  ssp_in = ssp_ff;
      pk_in   = pk_ff;   pv_in  = pv_ff;  rnd_in = rnd_ff;
      a       = pc_ff;   wdata  = acc_ff;
      chk     = 1'b0;    wr_req = 1'b0;   halt   = 1'b0;
      case (cmd.phase)
         PH_CLEAR: begin
            a      = 32'(clr_ff);
            wdata  = '0;
            wr_req = 1'b1;
            clr_in = clr_ff + AW'(1);
         end
         PH_IDLE: begin
            if (cmd.accept) begin
               pk_in  = PK_NONE;
               pv_in  = '0;
               rnd_in = req_payload.random_value;
               a      = 32'(req_payload.load_address);
               wdata  = req_payload.load_value;
               wr_req = (req_payload.opcode == ITEM_LOAD) && (a < MEM_W);
            end
         end
         PH_FETCH: begin
            a   = pc_ff;
            chk = 1'b1;
         end
         PH_DECODE: begin
            ir_in = rdata_ff;
            case (rdata_ff)
               OP_LDI, OP_LDD, OP_LDN, OP_LDX, OP_LDY, OP_STO,
               OP_PUT, OP_JMP, OP_JZ, OP_JNZ, OP_CALL: begin
                  pc_in = pc_ff + 32'd1;
                  a     = pc_ff + 32'd1;
                  chk   = 1'b1;
               end
               OP_LDS: begin
                  a   = sp_ff + x_ff;
                  chk = 1'b1;
               end
               OP_RET, OP_POP: begin
                  a     = sp_ff;
                  chk   = 1'b1;
                  sp_in = sp_ff + 32'd1;
               end
               OP_IRET: begin
                  a      = sp_ff;
                  chk    = 1'b1;
                  ssp_in = sp_ff + 32'd1;
               end
               OP_PUSH: begin
                  sp_in  = sp_ff - 32'd1;
                  a      = sp_ff - 32'd1;
                  wdata  = acc_ff;
                  wr_req = 1'b1;
                  chk    = 1'b1;
                  if (!addr_bad(sp_ff - 32'd1, km_ff)) pc_in = pc_ff + 32'd1;
               end
               OP_SYS: begin
                  if (intk_ff != INT_NONE) begin
                     stop_in = ST_NESTED;
                     halt    = 1'b1;
                  end else begin
                     intk_in = INT_SYSCALL;
                     km_in   = 1'b1;
                     a       = MEM_TOP1;
                     wdata   = pc_ff + 32'd1;
                     wr_req  = 1'b1;
                  end
               end
               OP_GET:  begin acc_in = 32'(rnd_ff);   pc_in = pc_ff + 32'd1; end
               OP_ADDX: begin acc_in = acc_ff + x_ff; pc_in = pc_ff + 32'd1; end
               OP_ADDY: begin acc_in = acc_ff + y_ff; pc_in = pc_ff + 32'd1; end
               OP_SUBX: begin acc_in = acc_ff - x_ff; pc_in = pc_ff + 32'd1; end
               OP_SUBY: begin acc_in = acc_ff - y_ff; pc_in = pc_ff + 32'd1; end
               OP_CPAX: begin x_in = acc_ff;          pc_in = pc_ff + 32'd1; end
               OP_CPXA: begin acc_in = x_ff;          pc_in = pc_ff + 32'd1; end
               OP_CPAY: begin y_in = acc_ff;          pc_in = pc_ff + 32'd1; end
               OP_CPYA: begin acc_in = y_ff;          pc_in = pc_ff + 32'd1; end
               OP_CPAS: begin sp_in = acc_ff;         pc_in = pc_ff + 32'd1; end
               OP_CPSA: begin acc_in = sp_ff;         pc_in = pc_ff + 32'd1; end
               OP_INCX: begin x_in = x_ff + 32'd1;    pc_in = pc_ff + 32'd1; end
               OP_DECX: begin x_in = x_ff - 32'd1;    pc_in = pc_ff + 32'd1; end
               OP_EXIT: begin stop_in = ST_EXIT;  halt = 1'b1; end
               OP_EMPTY: begin stop_in = ST_EMPTY; halt = 1'b1; end
               default: begin stop_in = ST_UNKNOWN; halt = 1'b1; end
            endcase
         end
         PH_OPND: begin
            case (ir_ff)
               OP_LDI: begin acc_in = rdata_ff; pc_in = pc_ff + 32'd1; end
               OP_LDD, OP_LDN: begin a = rdata_ff;        chk = 1'b1; end
               OP_LDX: begin a = rdata_ff + x_ff; chk = 1'b1; end
               OP_LDY: begin a = rdata_ff + y_ff; chk = 1'b1; end
               OP_STO: begin
                  a      = rdata_ff;
                  wdata  = acc_ff;
                  wr_req = 1'b1;
                  chk    = 1'b1;
                  if (!addr_bad(rdata_ff, km_ff)) pc_in = pc_ff + 32'd1;
               end
               OP_PUT: begin
                  if (rdata_ff == PORT_INT) begin
                     pk_in = PK_INT;
                     pv_in = acc_ff;
                     pc_in = pc_ff + 32'd1;
                  end else if (rdata_ff == PORT_CHAR) begin
                     pk_in = PK_CHAR;
                     pv_in = {24'd0, acc_ff[7:0]};
                     pc_in = pc_ff + 32'd1;
                  end else begin
                     stop_in = ST_PORT;
                     halt    = 1'b1;
                  end
               end
               OP_JMP: pc_in = rdata_ff;
               OP_JZ, OP_JNZ: begin
                  if ((ir_ff == OP_JZ) == (acc_ff == 32'd0)) pc_in = rdata_ff;
                  else pc_in = pc_ff + 32'd1;
               end
               OP_CALL: begin
                  sp_in  = sp_ff - 32'd1;
                  a      = sp_ff - 32'd1;
                  wdata  = pc_ff;
                  wr_req = 1'b1;
                  chk    = 1'b1;
                  if (!addr_bad(sp_ff - 32'd1, km_ff)) pc_in = rdata_ff;
               end
               default: begin
               end
            endcase
         end
         PH_DATA: begin
            if (ir_ff == OP_LDN) begin
               a   = rdata_ff;
               chk = 1'b1;
            end else begin
               acc_in = rdata_ff;
               pc_in  = pc_ff + 32'd1;
            end
         end
         PH_DATA2: begin
            if (ir_ff == OP_RET) begin
               pc_in = rdata_ff + 32'd1;
            end else begin
               acc_in = rdata_ff;
               pc_in  = pc_ff + 32'd1;
            end
         end
         PH_IRET1: begin
            sp_in = rdata_ff;
            a     = ssp_ff;
            chk   = 1'b1;
         end
         PH_IRET2: begin
            pc_in   = rdata_ff;
            km_in   = 1'b0;
            intk_in = INT_NONE;
         end
         PH_TIMER: begin
            if (timer_due) begin
               tick_in = '0;
               intk_in = INT_TIMER;
               km_in   = 1'b1;
               a       = MEM_TOP1;
               wdata   = pc_ff;
               wr_req  = 1'b1;
            end else begin
               tick_in = tick_inc;
               if (intk_ff == INT_TIMER && tick_inc >= {16'd0, period_ff}) stop_in = ST_OVERRUN;
            end
         end
         PH_PUSH2: begin
            a      = MEM_TOP2;
            wdata  = sp_ff;
            wr_req = 1'b1;
            sp_in  = MEM_TOP2;
            if (intk_ff == INT_SYSCALL) begin
               pc_in = ADDR_SYSCALL_HANDLER;
            end else begin
               pc_in   = ADDR_TIMER_HANDLER;
               tick_in = tick_inc;
               if (tick_inc >= {16'd0, period_ff}) stop_in = ST_OVERRUN;
            end
         end
         default: begin
         end
      endcase
      // Protection check on the chosen address.
      bad = chk && addr_bad(a, km_ff);
      if (bad) begin
         stop_in = ST_MEMV;
         halt    = 1'b1;
      end
      we = wr_req && !bad;
   end

   // Word memory with registered read.
   always_ff @(posedge clock) begin
      if (we) mem[a[AW-1:0]] <= wdata;
      rdata_ff <= mem[a[AW-1:0]];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         sp_ff        <= MEM_H;
         acc_ff       <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         km_ff        <= 1'b0;
         intk_ff      <= INT_NONE;
         tick_ff      <= '0;
         stop_ff      <= ST_RUN;
         period_ff    <= TIMER_PERIOD_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         sp_ff   <= sp_in;
         acc_ff  <= acc_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         km_ff   <= km_in;
         intk_ff <= intk_in;
         tick_ff <= tick_in;
         stop_ff <= stop_in;
         clr_ff  <= clr_in;
         if (csr_write_enable) period_ff <= csr_write_data;
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ir_ff  <= ir_in;
      ssp_ff <= ssp_in;
      pk_ff  <= pk_in;
      pv_ff  <= pv_in;
      rnd_ff <= rnd_in;
      if (cmd.load_rsp) begin
         rsp_ff.port_kind           <= pk_ff;
         rsp_ff.port_value          <= pv_ff;
         rsp_ff.run_status          <= stop_ff;
         rsp_ff.program_counter_out <= pc_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Status to the controller.
   assign st.ir         = (cmd.phase == PH_DECODE) ? rdata_ff : ir_ff;
   assign st.halt       = halt;
   assign st.intk       = intk_ff;
   assign st.timer_due  = timer_due;
   assign st.stopped    = (stop_ff != ST_RUN);
   assign st.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign st.clear_last = (clr_ff == CLR_LAST);

endmodule

FILE: sv/acpu_checker.sv
// Port-level checker for the accumulator CPU, bound to the top level.
module acpu_checker import acpu_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // A result beat that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   // The block works on one item at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted twice in a row");

   // No port output means a zero port value.
   a_no_port: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.port_kind == PK_NONE |-> rsp_payload.port_value == 32'd0)
      else $error("port value without port output");

   // A character output carries only eight bits.
   a_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.port_kind == PK_CHAR |-> rsp_payload.port_value[31:8] == 24'd0)
      else $error("character output wider than a byte");

   // The port kind is never the unused code.
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.port_kind != 2'd3)
      else $error("invalid port kind");

endmodule

bind accumulator_cpu_with_interrupts_core acpu_checker u_acpu_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

FILE: verif/tb_accumulator_cpu_with_interrupts_core.sv
// Self-checking testbench for the accumulator CPU core with a scoreboard class.
`timescale 1ns / 100ps

module tb_accumulator_cpu_with_interrupts_core;
   import acpu_pkg::*;

   localparam int MEM_WORDS = 2000;
   localparam int AW = $clog2(MEM_WORDS);
   localparam int WATCHDOG_LIMIT = 20000;
   // Address map kept by the program builder.
   localparam logic [31:0] USER_CODE_TOP = 32'd590;
   localparam logic [31:0] USER_PC_MAX = 32'd597;
   localparam logic [31:0] KERNEL_CODE_TOP = 32'd1980;
   localparam logic [31:0] DATA_LO = 32'd600;
   localparam logic [31:0] DATA_HI = 32'd999;
   localparam logic [31:0] PORT_BAD = 32'd3;
   localparam logic [31:0] OP_UNUSED = 32'd31;
   localparam logic [31:0] OP_ANY = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   // Mirror of the CPU state that predicts the result beat of every accepted item.
   class cpu_scoreboard;
      logic [31:0] mem [MEM_WORDS];
      logic [31:0] pc, sp, acc, x, y, ticks;
      bit          kmode;
      logic [1:0]  intk;
      logic [2:0]  status;
      logic [15:0] period;
      rsp_type     pending[$];
      int          errors, n_load, n_exec, n_timer, n_sys;

      function new();
         for (int i = 0; i < MEM_WORDS; i++) mem[i] = '0;
         pc = '0; sp = MEM_WORDS / 2; acc = '0; x = '0; y = '0; ticks = '0;
         kmode = 0; intk = INT_NONE; status = ST_RUN; period = TIMER_PERIOD_RESET;
         errors = 0; n_load = 0; n_exec = 0; n_timer = 0; n_sys = 0;
      endfunction

      function bit addr_ok(logic [31:0] a);
         if (a >= MEM_WORDS) return 0;
         if (!kmode && a >= MEM_WORDS / 2) return 0;
         return 1;
      endfunction

      function bit rd(logic [31:0] a, output logic [31:0] v);
         v = '0;
         if (!addr_ok(a)) begin
            status = ST_MEMV;
            return 0;
         end
         v = mem[AW'(a)];
         return 1;
      endfunction

      function bit wr(logic [31:0] a, logic [31:0] v);
         if (!addr_ok(a)) begin
            status = ST_MEMV;
            return 0;
         end
         mem[AW'(a)] = v;
         return 1;
      endfunction

      function bit operand(output logic [31:0] v);
         pc = pc + 1;
         return rd(pc, v);
      endfunction

      // Interrupt entry: push return PC and user SP onto the kernel stack.
      function bit enter_int(logic [1:0] kind, logic [31:0] ret_pc, logic [31:0] handler);
         logic [31:0] ssp;
         ssp = MEM_WORDS;
         intk = kind;
         kmode = 1;
         ssp = ssp - 1;
         if (!wr(ssp, ret_pc)) return 0;
         ssp = ssp - 1;
         if (!wr(ssp, sp)) return 0;
         sp = ssp;
         pc = handler;
         return 1;
      endfunction

      // One instruction; returns 1 when it completed without stopping.
      function bit run_word(logic [6:0] rnd, output logic [1:0] pk, output logic [31:0] pv);
         logic [31:0] ir, o, t, a, ssp, nsp;
         pk = PK_NONE;
         pv = '0;
         if (!rd(pc, ir)) return 0;
         case (ir)
            OP_LDI: begin
               if (!operand(o)) return 0;
               acc = o;
            end
            OP_LDD: begin
               if (!operand(o)) return 0;
               if (!rd(o, t)) return 0;
               acc = t;
            end
            OP_LDN: begin
               if (!operand(o)) return 0;
               if (!rd(o, t)) return 0;
               if (!rd(t, t)) return 0;
               acc = t;
            end
            OP_LDX: begin
               if (!operand(o)) return 0;
               if (!rd(o + x, t)) return 0;
               acc = t;
            end
            OP_LDY: begin
               if (!operand(o)) return 0;
               if (!rd(o + y, t)) return 0;
               acc = t;
            end
            OP_LDS: begin
               if (!rd(sp + x, t)) return 0;
               acc = t;
            end
            OP_STO: begin
               if (!operand(o)) return 0;
               if (!wr(o, acc)) return 0;
            end
            OP_GET: acc = {25'd0, rnd};
            OP_PUT: begin
               if (!operand(o)) return 0;
               if (o == PORT_INT) begin
                  pk = PK_INT;
                  pv = acc;
               end else if (o == PORT_CHAR) begin
                  pk = PK_CHAR;
                  pv = {24'd0, acc[7:0]};
               end else begin
                  status = ST_PORT;
                  return 0;
               end
            end
            OP_ADDX: acc = acc + x;
            OP_ADDY: acc = acc + y;
            OP_SUBX: acc = acc - x;
            OP_SUBY: acc = acc - y;
            OP_CPAX: x = acc;
            OP_CPXA: acc = x;
            OP_CPAY: y = acc;
            OP_CPYA: acc = y;
            OP_CPAS: sp = acc;
            OP_CPSA: acc = sp;
            OP_JMP: begin
               if (!operand(o)) return 0;
               pc = o;
               return 1;
            end
            OP_JZ, OP_JNZ: begin
               if (!operand(o)) return 0;
               if ((ir == OP_JZ) == (acc == 0)) begin
                  pc = o;
                  return 1;
               end
            end
            OP_CALL: begin
               if (!operand(o)) return 0;
               sp = sp - 1;
               if (!wr(sp, pc)) return 0;
               pc = o;
               return 1;
            end
            OP_RET: begin
               a = sp;
               sp = sp + 1;
               if (!rd(a, t)) return 0;
               pc = t;
            end
            OP_INCX: x = x + 1;
            OP_DECX: x = x - 1;
            OP_PUSH: begin
               sp = sp - 1;
               if (!wr(sp, acc)) return 0;
            end
            OP_POP: begin
               a = sp;
               sp = sp + 1;
               if (!rd(a, t)) return 0;
               acc = t;
            end
            OP_SYS: begin
               if (intk != INT_NONE) begin
                  status = ST_NESTED;
                  return 0;
               end
               n_sys++;
               return enter_int(INT_SYSCALL, pc + 1, ADDR_SYSCALL_HANDLER);
            end
            OP_IRET: begin
               ssp = sp;
               a = ssp;
               ssp = ssp + 1;
               if (!rd(a, nsp)) return 0;
               sp = nsp;
               a = ssp;
               ssp = ssp + 1;
               if (!rd(a, t)) return 0;
               pc = t;
               kmode = 0;
               intk = INT_NONE;
               return 1;
            end
            OP_EXIT: begin
               status = ST_EXIT;
               return 0;
            end
            OP_EMPTY: begin
               status = ST_EMPTY;
               return 0;
            end
            default: begin
               status = ST_UNKNOWN;
               return 0;
            end
         endcase
         pc = pc + 1;
         return 1;
      endfunction

      // Accepted input beat: update the state and queue the expected result beat.
      function void note_input(req_type item);
         logic [1:0]  pk;
         logic [31:0] pv;
         rsp_type     e;
         bit          ok;
         pk = PK_NONE;
         pv = '0;
         if (item.opcode == ITEM_LOAD) begin
            n_load++;
            if (item.load_address < MEM_WORDS) mem[item.load_address] = item.load_value;
         end else begin
            n_exec++;
            if (status == ST_RUN && run_word(item.random_value, pk, pv)) begin
               ok = 1;
               if (intk == INT_NONE && ticks >= {16'd0, period}) begin
                  ticks = '0;
                  n_timer++;
                  ok = enter_int(INT_TIMER, pc, ADDR_TIMER_HANDLER);
               end
               if (ok) begin
                  ticks = ticks + 1;
                  if (intk == INT_TIMER && ticks >= {16'd0, period}) status = ST_OVERRUN;
               end
            end
         end
         e.port_kind = pk;
         e.port_value = pv;
         e.run_status = status;
         e.program_counter_out = pc;
         pending.push_back(e);
      endfunction

      function void report(string what, logic [31:0] e, logic [31:0] g);
         errors++;
         $display("%0t: %s mismatch: expected %h, got %h", $time, what, e, g);
      endfunction

      // Accepted result beat: compare with the oldest expectation.
      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: result beat with none expected: %h", $time, got);
            return;
         end
         e = pending.pop_front();
         if (got.port_kind !== e.port_kind)
            report("port_kind", 32'(e.port_kind), 32'(got.port_kind));
         if (got.port_value !== e.port_value) report("port_value", e.port_value, got.port_value);
         if (got.run_status !== e.run_status)
            report("run_status", 32'(e.run_status), 32'(got.run_status));
         if (got.program_counter_out !== e.program_counter_out)
            report("program_counter", e.program_counter_out, got.program_counter_out);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_payload;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;

   cpu_scoreboard sb;
   int          burst_left;
   int          n_sent;
   int          idle_cycles;
   int          cycle_count;
   rx_mode_type rx_mode;

   accumulator_cpu_with_interrupts_core #(.MEM_WORDS(MEM_WORDS)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   // Result side: check beats, stall on a changing pattern, watch for a hang.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_payload);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("FAIL accumulator_cpu_with_interrupts_core");
            $finish;
         end
      end
      if (cycle_count % 128 == 0) rx_mode <= rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN: rsp_ready <= 1'b1;
         RX_HALF: rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= cycle_count[3];
      endcase
   end

   // Send one beat; bursts of random length are separated by random gaps.
   task automatic send_item(input req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_input(item);
      n_sent++;
   endtask

   task automatic send_load(input logic [31:0] addr, input logic [31:0] value);
      req_type item;
      item.opcode = ITEM_LOAD;
      item.load_address = addr[10:0];
      item.load_value = value;
      item.random_value = 7'($urandom);
      send_item(item);
   endtask

   task automatic send_exec();
      req_type item;
      int      pick;
      pick = $urandom_range(0, 5);
      item.opcode = ~ITEM_LOAD;
      item.load_address = 11'($urandom);
      item.load_value = $urandom;
      item.random_value = (pick == 0) ? 7'd0 : (pick == 1) ? 7'h7F : 7'($urandom_range(1, 100));
      send_item(item);
   endtask

   // Stop sending and wait until every expected result beat has come.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_period(input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.period = value;
   endtask

   // Choose operands for an instruction so that it runs without stopping the CPU.
   function automatic bit plan_op(input logic [31:0] ir, input logic [31:0] lo,
                                  input logic [31:0] hi, output logic [31:0] opnd,
                                  output bit two, output bit aux,
                                  output logic [31:0] aux_a, output logic [31:0] aux_v);
      bit user;
      bit push_room;
      user = !sb.kmode;
      push_room = (sb.sp - 1 >= DATA_LO) && (sb.sp - 1 <= DATA_HI);
      opnd = '0;
      two = 1;
      aux = 0;
      aux_a = '0;
      aux_v = '0;
      case (ir)
         OP_LDI: opnd = ($urandom_range(0, 9) < 4) ? $urandom_range(0, 1999) : $urandom;
         OP_LDD, OP_STO: opnd = $urandom_range(DATA_LO, DATA_HI);
         OP_LDN: begin
            opnd = $urandom_range(DATA_LO, 899);
            aux = 1;
            aux_a = opnd;
            aux_v = $urandom_range(0, user ? 999 : 1999);
         end
         OP_LDX: opnd = $urandom_range(0, 999) - sb.x;
         OP_LDY: opnd = $urandom_range(0, 999) - sb.y;
         OP_PUT: opnd = $urandom_range(0, 1) ? PORT_INT : PORT_CHAR;
         OP_JMP, OP_JZ, OP_JNZ: opnd = $urandom_range(lo, hi);
         OP_CALL: begin
            opnd = $urandom_range(lo, hi);
            return user && push_room;
         end
         default: two = 0;
      endcase
      case (ir)
         OP_LDI, OP_LDD, OP_LDN, OP_LDX, OP_LDY, OP_STO, OP_PUT, OP_JMP, OP_JZ, OP_JNZ,
         OP_GET, OP_ADDX, OP_ADDY, OP_SUBX, OP_SUBY, OP_CPAX, OP_CPXA, OP_CPAY, OP_CPYA,
         OP_CPSA, OP_INCX, OP_DECX: return 1;
         OP_LDS: return sb.addr_ok(sb.sp + sb.x);
         OP_CPAS: return user && sb.acc >= 601 && sb.acc <= 1000;
         OP_RET: return user && sb.addr_ok(sb.sp) && sb.mem[AW'(sb.sp)] <= USER_PC_MAX;
         OP_PUSH: return user && push_room;
         OP_POP: return user && sb.addr_ok(sb.sp);
         OP_SYS: return user;
         OP_IRET: return sb.addr_ok(sb.sp) && sb.addr_ok(sb.sp + 1)
                         && sb.mem[AW'(sb.sp + 1)] <= USER_PC_MAX;
         default: return 0;
      endcase
   endfunction

   // Write a fresh instruction at the current PC and execute it.
   task automatic run_instruction(input logic [31:0] want);
      logic [31:0] p, ir, opnd, lo, hi, aux_a, aux_v;
      bit          two, aux, legal;
      p = sb.pc;
      if (sb.kmode) begin
         lo = 1000;
         hi = KERNEL_CODE_TOP;
      end else begin
         lo = 0;
         hi = USER_CODE_TOP;
      end
      // Leave the timer handler before the tick count runs out.
      if (sb.intk == INT_TIMER && sb.ticks + 1 >= {16'd0, sb.period}) want = OP_IRET;
      if (sb.intk == INT_SYSCALL && $urandom_range(0, 6) == 0) want = OP_IRET;
      if (p > hi + 1) want = OP_JMP;
      ir = want;
      legal = plan_op(ir, lo, hi, opnd, two, aux, aux_a, aux_v);
      while (!legal) begin
         ir = $urandom_range(1, 30);
         legal = plan_op(ir, lo, hi, opnd, two, aux, aux_a, aux_v);
      end
      // Occasional stray load into the data area or past the end of memory.
      if ($urandom_range(0, 6) == 0)
         send_load($urandom_range(0, 1) ? $urandom_range(DATA_LO, 899) : $urandom_range(2000, 2047),
                   $urandom);
      if (aux) send_load(aux_a, aux_v);
      send_load(p, ir);
      if (two) send_load(p + 1, opnd);
      send_exec();
   endtask

   task automatic random_phase(input int target);
      while (n_sent < target) run_instruction(OP_ANY);
   endtask

   // Final phase: force one way of stopping, then check the stopped reports.
   task automatic stop_machine();
      int kind;
      int guard;
      kind = $urandom_range(0, 6);
      case (kind)
         0: begin
            send_load(sb.pc, OP_EXIT);
            send_exec();
         end
         1: begin
            send_load(sb.pc, OP_LDD);
            send_load(sb.pc + 1, 32'hFFFF_FF00);
            send_exec();
         end
         2: begin
            send_load(sb.pc, OP_EMPTY);
            send_exec();
         end
         3: begin
            send_load(sb.pc, OP_UNUSED);
            send_exec();
         end
         4: begin
            send_load(sb.pc, OP_PUT);
            send_load(sb.pc + 1, PORT_BAD);
            send_exec();
         end
         5: begin
            if (!sb.kmode) begin
               send_load(sb.pc, OP_SYS);
               send_exec();
            end
            send_load(sb.pc, OP_SYS);
            send_exec();
         end
         default: begin
            drain();
            write_period(16'($urandom_range(0, 1)));
            guard = 0;
            while (sb.status == ST_RUN && guard < 200) begin
               run_instruction(OP_ANY);
               guard++;
            end
         end
      endcase
      repeat (6) begin
         if ($urandom_range(0, 1)) send_exec();
         else send_load($urandom_range(DATA_LO, 899), $urandom);
      end
   endtask

   initial begin
      logic [31:0] tour [$];
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      burst_left = 0;
      n_sent = 0;
      idle_cycles = 0;
      cycle_count = 0;
      rx_mode = RX_OPEN;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, then a tour that asks for each instruction in turn at the reset period.
      send_load(32'd0, 32'h7FFF_FFFF);
      send_load(32'd1999, 32'h8000_0000);
      send_load(32'd2047, 32'hFFFF_FFFF);
      send_load(32'd1024, 32'h0000_0000);
      tour = '{OP_LDI, OP_LDD, OP_LDN, OP_LDX, OP_LDY, OP_LDS, OP_STO, OP_GET, OP_PUT,
               OP_ADDX, OP_ADDY, OP_SUBX, OP_SUBY, OP_CPAX, OP_CPXA, OP_CPAY, OP_CPYA,
               OP_CPSA, OP_CPAS, OP_JMP, OP_JZ, OP_JNZ, OP_INCX, OP_DECX, OP_CALL, OP_RET,
               OP_PUSH, OP_POP, OP_SYS, OP_IRET};
      foreach (tour[i]) run_instruction(tour[i]);

      // Random programs under several timer periods, idle between settings.
      random_phase(220);
      drain();
      write_period(16'hFFFF);
      random_phase(380);
      drain();
      write_period(16'd2);
      random_phase(540);
      drain();
      write_period(16'($urandom_range(3, 60)));
      random_phase(750);
      stop_machine();

      drain();
      repeat (20) @(posedge clock);
      if (sb.pending.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d result beats never arrived", $time, sb.pending.size());
      end
      $display("Covered %0d load and %0d execute beats, %0d timer and %0d syscall entries,",
               sb.n_load, sb.n_exec, sb.n_timer, sb.n_sys);
      $display("several timer periods, and a final stop with status %0d.", sb.status);
      if (sb.errors == 0) begin
         $display("PASS accumulator_cpu_with_interrupts_core");
      end else begin
         $display("FAIL accumulator_cpu_with_interrupts_core");
      end
      $finish;
   end

endmodule
